### hdl/mcst_pkg.sv
// Package for the multi-channel soft timer unit: command and result types,
// operation, status and state codes, and default sizes. No dependencies.
package mcst_pkg;

  localparam int unsigned NumTimersDef = 8;
  localparam int unsigned CmdFifoDepth = 2;
  localparam logic [15:0] MaxPeriodRst = 16'hFFFF;

  localparam int unsigned TdataInW  = 72;
  localparam int unsigned TuserInW  = 3;
  localparam int unsigned TdataOutW = 24;

  // Input kind codes as they arrive on the stream.
  localparam logic [2:0] KIND_ALLOC     = 3'd0;
  localparam logic [2:0] KIND_START     = 3'd1;
  localparam logic [2:0] KIND_START_PER = 3'd2;
  localparam logic [2:0] KIND_STOP      = 3'd3;
  localparam logic [2:0] KIND_TICK      = 3'd4;
  localparam logic [2:0] KIND_FREE      = 3'd5;

  // Result status codes.
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NO_SLOT    = 2'd1;
  localparam logic [1:0] ST_BAD_PERIOD = 2'd2;

  typedef enum logic [2:0] {
    OP_ALLOC,
    OP_START,
    OP_START_PER,
    OP_STOP,
    OP_TICK,
    OP_FREE,
    OP_BAD
  } op_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_TEND
  } bk_state_e;

  typedef struct packed {
    op_e         op;
    logic [2:0]  idx;
    logic [15:0] period;
    logic        reload;
    logic [15:0] tag;
    logic [31:0] now;
    logic        period_ok;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  idx;
    logic        fired;
    logic [15:0] tag;
    logic        last;
  } res_t;

endpackage

### hdl/multi_channel_soft_timer_unit.sv
// A non-tick command's result goes to the output register when the executor
// takes the command from the queue; a tick is taken from the queue, then the
// channels are scanned one per cycle (unless a stalled result holds the scan),
// then a closing step sends the last result. Throughput: one non-tick command
// per cycle when idle and unstalled; the table scan sets tick cost.
// Reset (rst_ni, asynchronous, active low) frees all channels, empties the queue.
module multi_channel_soft_timer_unit #(
  parameter int unsigned NUM_TIMERS = mcst_pkg::NumTimersDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Command stream.
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // tdata from bit 0 up: timer_index[2:0], period[18:3], reload_mode[19],
  // tag[35:20], now[67:36], zero padding[71:68].
  input  logic [mcst_pkg::TdataInW-1:0]   s_axis_tdata_i,
  // tuser: kind[2:0].
  input  logic [mcst_pkg::TuserInW-1:0]   s_axis_tuser_i,
  // Result stream.
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // tdata from bit 0 up: status[1:0], timer_index_res[4:2],
  // expired_tag[20:5], zero padding[23:21].
  output logic [mcst_pkg::TdataOutW-1:0]  m_axis_tdata_o,
  // tuser: fired[0].
  output logic                            m_axis_tuser_o,
  output logic                            m_axis_tlast_o,
  // max_period register write.
  input  logic                            cfg_we_i,
  input  logic [15:0]                     cfg_wdata_i
);
  import mcst_pkg::*;

  // The front end decodes each command transaction and checks its period
  // against max_period; decoded commands wait in a short queue so that the
  // input side keeps accepting, until the queue fills, during a tick scan.
  // Reset also sets max_period back to 65535.
  cmd_t front_cmd;
  cmd_t head_cmd;
  logic front_push;
  logic fifo_full;
  logic fifo_valid;
  logic fifo_pop;

  mcst_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .fifo_full_i     (fifo_full),
    .push_o          (front_push),
    .cmd_o           (front_cmd)
  );

  mcst_cmd_fifo #(
    .DEPTH (CmdFifoDepth)
  ) u_cmd_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (front_push),
    .push_data_i (front_cmd),
    .pop_i       (fifo_pop),
    .full_o      (fifo_full),
    .valid_o     (fifo_valid),
    .data_o      (head_cmd)
  );

  // The executor owns the channel table and the output register. On a tick
  // it holds each expired channel in a pending register until the next one
  // or the end of the scan, so that the last fired result can carry tlast.
  mcst_back #(
    .NUM_TIMERS (NUM_TIMERS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (fifo_valid),
    .cmd_i           (head_cmd),
    .pop_o           (fifo_pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

### hdl/mcst_front.sv
// Front end of the soft timer unit: accepts command transactions, decodes the
// kind, checks the period against the max_period register. Uses mcst_pkg.
module mcst_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [mcst_pkg::TdataInW-1:0]   s_axis_tdata_i,
  input  logic [mcst_pkg::TuserInW-1:0]   s_axis_tuser_i,
  input  logic                            cfg_we_i,
  input  logic [15:0]                     cfg_wdata_i,
  input  logic                            fifo_full_i,
  output logic                            push_o,
  output mcst_pkg::cmd_t                  cmd_o
);
  import mcst_pkg::*;

  logic [15:0] max_period_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_period_q <= MaxPeriodRst;
    end else if (cfg_we_i) begin
      max_period_q <= cfg_wdata_i;
    end
  end

  assign s_axis_tready_o = !fifo_full_i;
  assign push_o          = s_axis_tvalid_i && !fifo_full_i;

  always_comb begin
    cmd_o.idx       = s_axis_tdata_i[2:0];
    cmd_o.period    = s_axis_tdata_i[18:3];
    cmd_o.reload    = s_axis_tdata_i[19];
    cmd_o.tag       = s_axis_tdata_i[35:20];
    cmd_o.now       = s_axis_tdata_i[67:36];
    cmd_o.period_ok = (s_axis_tdata_i[18:3] != 16'd0) &&
                      (s_axis_tdata_i[18:3] <= max_period_q);
    case (s_axis_tuser_i)
      KIND_ALLOC:     cmd_o.op = OP_ALLOC;
      KIND_START:     cmd_o.op = OP_START;
      KIND_START_PER: cmd_o.op = OP_START_PER;
      KIND_STOP:      cmd_o.op = OP_STOP;
      KIND_TICK:      cmd_o.op = OP_TICK;
      KIND_FREE:      cmd_o.op = OP_FREE;
      default:        cmd_o.op = OP_BAD;
    endcase
  end

endmodule

### hdl/mcst_cmd_fifo.sv
// Short command queue between the front end and the executor of the soft
// timer unit. Holds decoded commands of type mcst_pkg::cmd_t.
module mcst_cmd_fifo #(
  parameter int unsigned DEPTH = mcst_pkg::CmdFifoDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mcst_pkg::cmd_t push_data_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           valid_o,
  output mcst_pkg::cmd_t data_o
);
  import mcst_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  cmd_t            mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### hdl/mcst_back.sv
// Executor of the soft timer unit: holds the channel table, carries out
// commands and scans channels on a tick, one per cycle unless stalled. Uses mcst_pkg.
module mcst_back #(
  parameter int unsigned NUM_TIMERS = mcst_pkg::NumTimersDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cmd_valid_i,
  input  mcst_pkg::cmd_t                  cmd_i,
  output logic                            pop_o,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [mcst_pkg::TdataOutW-1:0]  m_axis_tdata_o,
  output logic                            m_axis_tuser_o,
  output logic                            m_axis_tlast_o
);
  import mcst_pkg::*;

  localparam int unsigned IdxW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  // Channel table.
  logic [NUM_TIMERS-1:0]        alloc_q, run_q, periodic_q;
  logic [NUM_TIMERS-1:0][15:0]  period_q;
  logic [NUM_TIMERS-1:0][15:0]  tag_q;
  logic [NUM_TIMERS-1:0][31:0]  target_q;

  bk_state_e       state_q, state_d;
  cmd_t            tick_q, tick_d;
  logic [IdxW-1:0] scan_q, scan_d;
  res_t            pend_q, pend_d;
  logic            pend_vld_q, pend_vld_d;
  res_t            out_q, out_d;
  logic            out_vld_q, out_vld_d;

  logic            out_free;
  logic            out_load;
  res_t            out_res;
  logic [IdxW-1:0] rd_idx;
  logic [IdxW-1:0] free_idx;
  logic            full;
  logic            in_range;
  logic            slot_ok;
  logic            expire;
  logic [15:0]     new_per;

  // Table write port, one index per cycle.
  logic [IdxW-1:0] wr_idx;
  logic            we_alloc, alloc_val;
  logic            we_run, run_val;
  logic            we_periodic, periodic_val;
  logic            we_period, we_tag, we_target;
  logic [15:0]     period_val, tag_val;
  logic [31:0]     target_val;

  assign out_free = !out_vld_q || m_axis_tready_i;
  assign full     = &alloc_q;
  assign rd_idx   = (state_q == BK_SCAN) ? scan_q : IdxW'(cmd_i.idx);
  assign in_range = ({29'd0, cmd_i.idx} < 32'(NUM_TIMERS));
  assign slot_ok  = in_range && alloc_q[rd_idx];
  assign expire   = run_q[rd_idx] && (tick_q.now >= target_q[rd_idx]);
  assign new_per  = (cmd_i.op == OP_START_PER) ? cmd_i.period : period_q[rd_idx];

  always_comb begin
    free_idx = '0;
    for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
      if (!alloc_q[i]) begin
        free_idx = IdxW'(i);
      end
    end
  end

  always_comb begin
    state_d      = state_q;
    tick_d       = tick_q;
    scan_d       = scan_q;
    pend_d       = pend_q;
    pend_vld_d   = pend_vld_q;
    pop_o        = 1'b0;
    out_load     = 1'b0;
    out_res      = '0;
    out_res.last = 1'b1;
    wr_idx       = rd_idx;
    we_alloc     = 1'b0;
    alloc_val    = 1'b0;
    we_run       = 1'b0;
    run_val      = 1'b0;
    we_periodic  = 1'b0;
    periodic_val = 1'b0;
    we_period    = 1'b0;
    period_val   = cmd_i.period;
    we_tag       = 1'b0;
    tag_val      = cmd_i.tag;
    we_target    = 1'b0;
    target_val   = cmd_i.now + {16'd0, new_per};

    case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i && cmd_i.op == OP_TICK) begin
          pop_o      = 1'b1;
          tick_d     = cmd_i;
          scan_d     = '0;
          pend_vld_d = 1'b0;
          state_d    = BK_SCAN;
        end else if (cmd_valid_i && out_free) begin
          pop_o    = 1'b1;
          out_load = 1'b1;
          case (cmd_i.op)
            OP_ALLOC: begin
              if (full) begin
                out_res.status = ST_NO_SLOT;
              end else if (!cmd_i.period_ok) begin
                out_res.status = ST_BAD_PERIOD;
              end else begin
                wr_idx       = free_idx;
                we_alloc     = 1'b1;
                alloc_val    = 1'b1;
                we_run       = 1'b1;
                we_periodic  = 1'b1;
                periodic_val = cmd_i.reload;
                we_period    = 1'b1;
                we_tag       = 1'b1;
                out_res.idx  = 3'(free_idx);
              end
            end
            OP_START, OP_START_PER: begin
              out_res.idx = cmd_i.idx;
              if (!slot_ok) begin
                out_res.status = ST_NO_SLOT;
              end else if (cmd_i.op == OP_START_PER && !cmd_i.period_ok) begin
                out_res.status = ST_BAD_PERIOD;
              end else begin
                we_period = (cmd_i.op == OP_START_PER);
                we_target = 1'b1;
                we_run    = 1'b1;
                run_val   = 1'b1;
              end
            end
            OP_STOP: begin
              out_res.idx = cmd_i.idx;
              if (!slot_ok) begin
                out_res.status = ST_NO_SLOT;
              end else begin
                we_run = 1'b1;
              end
            end
            OP_FREE: begin
              out_res.idx = cmd_i.idx;
              if (!slot_ok) begin
                out_res.status = ST_NO_SLOT;
              end else begin
                we_alloc    = 1'b1;
                we_run      = 1'b1;
                we_periodic = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end

      BK_SCAN: begin
        // An expired channel waits in the pending register until the next
        // expiry or the end of the scan tells whether it is the last one.
        if (!(expire && pend_vld_q && !out_free)) begin
          if (expire) begin
            if (pend_vld_q) begin
              out_load = 1'b1;
              out_res  = pend_q;
            end
            pend_d.status = ST_OK;
            pend_d.idx    = 3'(scan_q);
            pend_d.fired  = 1'b1;
            pend_d.tag    = tag_q[rd_idx];
            pend_d.last   = 1'b0;
            pend_vld_d    = 1'b1;
            if (periodic_q[rd_idx]) begin
              we_target  = 1'b1;
              target_val = tick_q.now + {16'd0, period_q[rd_idx]};
            end else begin
              we_run = 1'b1;
            end
          end
          if (scan_q == IdxW'(NUM_TIMERS - 1)) begin
            state_d = BK_TEND;
          end else begin
            scan_d = scan_q + 1'b1;
          end
        end
      end

      BK_TEND: begin
        if (out_free) begin
          out_load = 1'b1;
          if (pend_vld_q) begin
            out_res      = pend_q;
            out_res.last = 1'b1;
          end
          pend_vld_d = 1'b0;
          state_d    = BK_IDLE;
        end
      end

      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_comb begin
    out_d     = out_q;
    out_vld_d = out_vld_q;
    if (out_load) begin
      out_d     = out_res;
      out_vld_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= BK_IDLE;
      scan_q     <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
      alloc_q    <= '0;
      run_q      <= '0;
      periodic_q <= '0;
    end else begin
      state_q    <= state_d;
      scan_q     <= scan_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
      if (we_alloc) begin
        alloc_q[wr_idx] <= alloc_val;
      end
      if (we_run) begin
        run_q[wr_idx] <= run_val;
      end
      if (we_periodic) begin
        periodic_q[wr_idx] <= periodic_val;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tick_q <= tick_d;
    pend_q <= pend_d;
    out_q  <= out_d;
    if (we_period) begin
      period_q[wr_idx] <= period_val;
    end
    if (we_tag) begin
      tag_q[wr_idx] <= tag_val;
    end
    if (we_target) begin
      target_q[wr_idx] <= target_val;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {3'd0, out_q.tag, out_q.idx, out_q.status};
  assign m_axis_tuser_o  = out_q.fired;
  assign m_axis_tlast_o  = out_q.last;

endmodule

### hdl/mcst_checker.sv
// Port-level checker for the soft timer unit, attached to the top level by
// the bind statement at the end of this file. Uses mcst_pkg.
module mcst_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i,
  input logic [mcst_pkg::TdataOutW-1:0]  m_axis_tdata_o,
  input logic                            m_axis_tuser_o,
  input logic                            m_axis_tlast_o
);
  import mcst_pkg::*;

  // A stalled result must hold still until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o)
      && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

  // A result that reports no expiry always closes its command.
  a_nonfired_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> m_axis_tlast_o)
    else $error("non-fired result without tlast");

  // An expiry report carries ok status.
  a_fired_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o[1:0] == ST_OK)
    else $error("fired result with error status");

  // Once a result without tlast is taken, a result that directly follows
  // it, if any, must be a fired result.
  a_fired_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o |=>
      !m_axis_tvalid_o || m_axis_tuser_o)
    else $error("tick result run broken");

endmodule

bind multi_channel_soft_timer_unit mcst_checker u_mcst_checker (.*);
